### design/fourth_order_crossover_core_defines.svh
// Assertion macros for the fourth-order crossover checker.
// Depends on nothing; the clock and reset names match the top-level ports.
`ifndef FOURTH_ORDER_CROSSOVER_CORE_DEFINES_SVH
`define FOURTH_ORDER_CROSSOVER_CORE_DEFINES_SVH

// Hold a consequence in the same cycle, outside reset.
`define FOC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Hold a consequence in the next cycle, outside reset.
`define FOC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

// Hold a consequence in the next cycle, reset included.
`define FOC_ASSERT_NEXT_RST(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) else $error(msg);

`endif

### design/foc_pkg.sv
// Shared constants and types for the fourth-order crossover.
// Used by the section cell and the top level.
`timescale 1ns / 1ps

package foc_pkg;

    localparam int SECTIONS  = 2;
    localparam int BANDS     = 2;
    localparam int SAMPLE_W  = 24;
    localparam int B0_W      = 30;
    localparam int A1_W      = 32;
    localparam int A2_W      = 31;
    localparam int MUL_A_W   = 32;
    localparam int MUL_B_W   = 27;
    localparam int PROD_W    = MUL_A_W + MUL_B_W;
    localparam int ACC_W     = PROD_W + 2;
    localparam int FRAC_BITS = 29;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LP_B0 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HP_B0 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_A1 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_A2 = 3'd4;

    typedef enum logic [1:0] {
        MODE_FILTER = 2'd0,
        MODE_LOW    = 2'd1,
        MODE_HIGH   = 2'd2,
        MODE_SPARE  = 2'd3
    } t_mode;

    typedef struct packed {
        logic                   highpass;
        logic [B0_W-1:0]        b0;
        logic signed [A1_W-1:0] a1;
        logic signed [A2_W-1:0] a2;
    } t_coef;

endpackage

### design/foc_cell.sv
// One direct-form-I biquad section with its own delay line and one shared multiplier.
// Depends on foc_pkg.
`timescale 1ns / 1ps

module foc_cell (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    input  logic signed [foc_pkg::SAMPLE_W-1:0]   i_x,
    input  foc_pkg::t_coef                        i_coef,
    output logic                                  o_done,
    output logic signed [foc_pkg::SAMPLE_W-1:0]   o_y
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL_FF,
        S_MUL_A1,
        S_MUL_A2,
        S_SUM,
        S_OUT
    } t_state;

    localparam logic signed [foc_pkg::MUL_A_W-1:0] S24_MAX = 32'sd8388607;
    localparam logic signed [foc_pkg::MUL_A_W-1:0] S24_MIN = -32'sd8388608;
    localparam logic signed [foc_pkg::ACC_W-1:0] ROUND_HALF =
        foc_pkg::ACC_W'(1) <<< (foc_pkg::FRAC_BITS - 1);

    t_state                                r_state;
    logic signed [foc_pkg::SAMPLE_W-1:0]   r_x, r_x1, r_x2, r_y1, r_y2, r_y;
    logic signed [foc_pkg::MUL_B_W-1:0]    r_sum;
    logic signed [foc_pkg::PROD_W-1:0]     r_prod;
    logic signed [foc_pkg::ACC_W-1:0]      r_acc;
    logic                                  r_done;

    logic signed [foc_pkg::MUL_B_W-1:0]    n_sum;
    logic signed [foc_pkg::MUL_A_W-1:0]    w_mul_a;
    logic signed [foc_pkg::MUL_B_W-1:0]    w_mul_b;
    logic signed [foc_pkg::PROD_W-1:0]     w_prod;
    logic signed [foc_pkg::MUL_A_W-1:0]    w_shift;
    logic signed [foc_pkg::SAMPLE_W-1:0]   n_y;

    // b0*x + b1*x1 + b2*x2 folds into b0*(x +/- 2*x1 + x2)
    always_comb begin
        if (i_coef.highpass) begin
            n_sum = foc_pkg::MUL_B_W'(i_x) - (foc_pkg::MUL_B_W'(r_x1) <<< 1)
                    + foc_pkg::MUL_B_W'(r_x2);
        end else begin
            n_sum = foc_pkg::MUL_B_W'(i_x) + (foc_pkg::MUL_B_W'(r_x1) <<< 1)
                    + foc_pkg::MUL_B_W'(r_x2);
        end
    end

    always_comb begin
        case (r_state)
            S_MUL_FF: begin
                w_mul_a = signed'({{(foc_pkg::MUL_A_W - foc_pkg::B0_W){1'b0}}, i_coef.b0});
                w_mul_b = r_sum;
            end
            S_MUL_A1: begin
                w_mul_a = i_coef.a1;
                w_mul_b = foc_pkg::MUL_B_W'(r_y1);
            end
            default: begin
                w_mul_a = foc_pkg::MUL_A_W'(i_coef.a2);
                w_mul_b = foc_pkg::MUL_B_W'(r_y2);
            end
        endcase
    end

    assign w_prod  = w_mul_a * w_mul_b;
    assign w_shift = r_acc[foc_pkg::ACC_W-1:foc_pkg::FRAC_BITS];

    always_comb begin
        if (w_shift > S24_MAX) begin
            n_y = S24_MAX[foc_pkg::SAMPLE_W-1:0];
        end else if (w_shift < S24_MIN) begin
            n_y = S24_MIN[foc_pkg::SAMPLE_W-1:0];
        end else begin
            n_y = w_shift[foc_pkg::SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
            r_x1    <= '0;
            r_x2    <= '0;
            r_y1    <= '0;
            r_y2    <= '0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_x     <= i_x;
                        r_sum   <= n_sum;
                        r_state <= S_MUL_FF;
                    end
                end
                S_MUL_FF: begin
                    r_prod  <= w_prod;
                    r_state <= S_MUL_A1;
                end
                S_MUL_A1: begin
                    r_acc   <= foc_pkg::ACC_W'(r_prod);
                    r_prod  <= w_prod;
                    r_state <= S_MUL_A2;
                end
                S_MUL_A2: begin
                    r_acc   <= r_acc - foc_pkg::ACC_W'(r_prod);
                    r_prod  <= w_prod;
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_acc   <= r_acc - foc_pkg::ACC_W'(r_prod) + ROUND_HALF;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    r_y     <= n_y;
                    r_done  <= 1'b1;
                    r_x2    <= r_x1;
                    r_x1    <= r_x;
                    r_y2    <= r_y1;
                    r_y1    <= n_y;
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_done = r_done;
    assign o_y    = r_y;

endmodule

### design/fourth_order_crossover_core.sv
// Fourth-order crossover top level: config registers, two chains of biquad cells, output skid.
// Depends on foc_pkg and foc_cell.
// Filter mode: each beat passes in turn through the SECTIONS cells of both chains to the output;
// a new input beat is taken only when the chain is idle and the result register is empty.
// Bypass modes: a beat passes the result then the output register; input waits for the result to move.
// Synchronous active-low reset clears the filter delay lines, empties the output and sets bypass-low.
`timescale 1ns / 1ps

module fourth_order_crossover_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [foc_pkg::CFG_IDX_W-1:0]    i_cfg_addr,
    input  logic [foc_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [23:0]                      s_axis_tdata,  // [23:0] sample
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [47:0]                      m_axis_tdata   // [23:0] low_sample, [47:24] high_sample
);

    localparam int S = foc_pkg::SECTIONS;

    foc_pkg::t_mode                          r_mode;
    logic [foc_pkg::B0_W-1:0]                r_lp_b0, r_hp_b0;
    logic signed [foc_pkg::A1_W-1:0]         r_a1;
    logic signed [foc_pkg::A2_W-1:0]         r_a2;
    logic                                    r_busy;
    logic                                    r_res_valid;
    logic signed [foc_pkg::SAMPLE_W-1:0]     r_res_low, r_res_high;
    logic                                    r_out_valid;
    logic signed [foc_pkg::SAMPLE_W-1:0]     r_out_low, r_out_high;

    logic                                    w_accept;
    logic                                    w_filter;
    logic                                    w_start;
    logic                                    w_move;
    logic signed [foc_pkg::SAMPLE_W-1:0]     w_x;
    foc_pkg::t_coef                          w_coef [foc_pkg::BANDS];
    logic                                    w_done [foc_pkg::BANDS][S];
    logic signed [foc_pkg::SAMPLE_W-1:0]     w_y    [foc_pkg::BANDS][S];

    assign w_x      = s_axis_tdata;
    assign w_filter = (r_mode == foc_pkg::MODE_FILTER) || (r_mode == foc_pkg::MODE_SPARE);
    assign s_axis_tready = !r_busy && !r_res_valid;
    assign w_accept = s_axis_tvalid && s_axis_tready;
    assign w_start  = w_accept && w_filter;
    assign w_move   = r_res_valid && (!r_out_valid || m_axis_tready);

    assign w_coef[0] = '{highpass: 1'b0, b0: r_lp_b0, a1: r_a1, a2: r_a2};
    assign w_coef[1] = '{highpass: 1'b1, b0: r_hp_b0, a1: r_a1, a2: r_a2};

    for (genvar b = 0; b < foc_pkg::BANDS; b++) begin : g_band
        for (genvar s = 0; s < S; s++) begin : g_sect
            if (s == 0) begin : g_head
                foc_cell u_cell (
                    .i_clk   (i_clk),
                    .i_rst_n (i_rst_n),
                    .i_start (w_start),
                    .i_x     (w_x),
                    .i_coef  (w_coef[b]),
                    .o_done  (w_done[b][s]),
                    .o_y     (w_y[b][s])
                );
            end else begin : g_link
                foc_cell u_cell (
                    .i_clk   (i_clk),
                    .i_rst_n (i_rst_n),
                    .i_start (w_done[b][s-1]),
                    .i_x     (w_y[b][s-1]),
                    .i_coef  (w_coef[b]),
                    .o_done  (w_done[b][s]),
                    .o_y     (w_y[b][s])
                );
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= foc_pkg::MODE_LOW;
            r_lp_b0 <= '0;
            r_hp_b0 <= '0;
            r_a1    <= '0;
            r_a2    <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                foc_pkg::CFG_MODE:  r_mode  <= foc_pkg::t_mode'(i_cfg_data[1:0]);
                foc_pkg::CFG_LP_B0: r_lp_b0 <= i_cfg_data[foc_pkg::B0_W-1:0];
                foc_pkg::CFG_HP_B0: r_hp_b0 <= i_cfg_data[foc_pkg::B0_W-1:0];
                foc_pkg::CFG_A1:    r_a1    <= signed'(i_cfg_data[foc_pkg::A1_W-1:0]);
                foc_pkg::CFG_A2:    r_a2    <= signed'(i_cfg_data[foc_pkg::A2_W-1:0]);
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_res_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_start) begin
                r_busy <= 1'b1;
            end else if (w_done[0][S-1]) begin
                r_busy      <= 1'b0;
                r_res_valid <= 1'b1;
                r_res_low   <= w_y[0][S-1];
                r_res_high  <= w_y[1][S-1];
            end
            if (w_accept && !w_filter) begin
                r_res_valid <= 1'b1;
                r_res_low   <= (r_mode == foc_pkg::MODE_LOW)  ? w_x : '0;
                r_res_high  <= (r_mode == foc_pkg::MODE_HIGH) ? w_x : '0;
            end
            if (w_move) begin
                r_res_valid <= 1'b0;
                r_out_valid <= 1'b1;
                r_out_low   <= r_res_low;
                r_out_high  <= r_res_high;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_high, r_out_low};

endmodule

### design/foc_checker.sv
// Port-level checks for the fourth-order crossover, bound to the top level.
// Depends on fourth_order_crossover_core_defines.svh.
`timescale 1ns / 1ps
`include "fourth_order_crossover_core_defines.svh"

module foc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_cfg_we,
    input logic [2:0]  i_cfg_addr,
    input logic [31:0] i_cfg_data,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [23:0] s_axis_tdata,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata
);

    `FOC_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "output beat dropped or changed while stalled")
    `FOC_ASSERT_NEXT_RST(a_reset_idle, !i_rst_n, !m_axis_tvalid && s_axis_tready, "block not idle after reset")
    `FOC_ASSERT_NEXT(a_one_in_flight, s_axis_tvalid && s_axis_tready, !s_axis_tready, "second beat taken before the first settled")
    `FOC_ASSERT_NOW(a_ready_known, i_rst_n, !$isunknown(s_axis_tready), "input ready unknown")

endmodule

bind fourth_order_crossover_core foc_checker u_foc_checker (.*);
